FILE: rtl/assert_macros.svh
// Assertion macros used by the checker of the operating point selector.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition that must hold at every clock edge outside reset.
`define OPS_ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("ops assertion failed");

// Same-cycle implication.
`define OPS_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ops assertion failed");

// Next-cycle implication.
`define OPS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ops assertion failed");

`endif

FILE: rtl/ops_pkg.sv
// Types and constants of the operating point selector.
package ops_pkg;

    // Operation codes carried in s_tuser; codes other than load and set act as a read.
    localparam logic [1:0] OP_LOAD = 2'd0;
    localparam logic [1:0] OP_SET  = 2'd1;

    // Configuration register indexes.
    localparam logic [0:0] REG_BUS_MULTIPLE = 1'b0;
    localparam logic [0:0] REG_POINT_COUNT  = 1'b1;

    localparam int S_TDATA_W  = 48;
    localparam int S_TUSER_W  = 2;
    localparam int M_TDATA_W  = 48;
    localparam int M_TUSER_W  = 1;
    localparam int CFG_DATA_W = 5;

    // Result field positions inside m_tdata.
    localparam int OUT_CHOSEN_LSB  = 16;
    localparam int OUT_WRITTEN_BIT = 44;

    localparam logic [3:0]  BUS_MULT_RESET   = 4'd3;
    localparam logic [12:0] VOLT_BASE_MV     = 13'd700;
    localparam logic [15:0] RATIO_OFFSET_MHZ = 16'd30;
    localparam logic [10:0] MHZ_PER_STEP     = 11'd100;

    // x/3 == (x * DIV3_RECIP) >> DIV3_SHIFT, exact for x below 2**21.
    localparam logic [19:0] DIV3_RECIP = 20'd699051;
    localparam int          DIV3_SHIFT = 21;

    typedef struct packed {
        logic [12:0] mv;
        logic [11:0] mhz;
    } point_t;

endpackage

FILE: rtl/operating_point_selector_top.sv
// Operating point selector: point table memory, control word and the set/read/load sequencer.
//
// The block holds a table of MAX_POINTS frequency/voltage operating points in a
// synchronous memory with one write port and one read port and a 16-bit performance control word (reset 0).
// One transaction in gives exactly one transaction out. Load (op 0) writes one
// table entry; set (op 1) picks an operating point for a target frequency and
// rewrites the control word; read (op 2, and op 3) reports the current frequency,
// (ratio*100*bus_multiple+1)/3 saturated to 16 bits. With point_count zero, set and
// read answer status 1 and all-zero data. Items are handled one at a time: a load
// or read passes through the decode states (multiply, scale, divide by 3) and then
// the finish state; a set whose target matches the current frequency does the same,
// and a set that selects a point also runs the table scan, which examines 1 to
// point_count entries, one memory read per cycle walking down from the last valid
// entry, and then the ratio divider that retires two quotient bits a cycle.
// A finished result waits in the output register while the next transaction is
// accepted. Configuration writes are taken every cycle and are only legal while
// the block is idle.
module operating_point_selector_top
    import ops_pkg::*;
#(
    parameter int MAX_POINTS = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // input stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // [3:0] entry_index, [15:4] entry_mhz, [28:16] entry_mv, [44:29] target_mhz
    input  logic [S_TDATA_W-1:0]  s_tdata,
    // [1:0] op
    input  logic [S_TUSER_W-1:0]  s_tuser,
    // result stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // [15:0] current_mhz, [27:16] chosen_mhz, [43:28] control_low,
    // [44] control_written
    output logic [M_TDATA_W-1:0]  m_tdata,
    // [0] status
    output logic [M_TUSER_W-1:0]  m_tuser,
    // configuration writes
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [0:0]            cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int IDX_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CNT_W = $clog2(MAX_POINTS + 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DEC_MUL,
        ST_DEC_SCALE,
        ST_DEC_DIV,
        ST_SCAN,
        ST_DIV,
        ST_FINISH
    } state_t;

    // input fields
    logic [1:0]  in_op;
    logic [3:0]  in_entry_index;
    logic [11:0] in_entry_mhz;
    logic [12:0] in_entry_mv;
    logic [15:0] in_target_mhz;

    assign in_op          = s_tuser[1:0];
    assign in_entry_index = s_tdata[3:0];
    assign in_entry_mhz   = s_tdata[15:4];
    assign in_entry_mv    = s_tdata[28:16];
    assign in_target_mhz  = s_tdata[44:29];

    // configuration
    logic [3:0] bus_mult_reg;
    logic [4:0] point_count_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bus_mult_reg    <= BUS_MULT_RESET;
            point_count_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_BUS_MULTIPLE: bus_mult_reg    <= cfg_data[3:0];
                REG_POINT_COUNT:  point_count_reg <= cfg_data[4:0];
                default: ;
            endcase
        end
    end

    // sequencer registers
    state_t            state_reg;
    logic [15:0]       control_word_reg;
    logic [1:0]        op_reg;
    logic [15:0]       target_reg;
    logic [CNT_W-1:0]  count_reg;
    logic              status_reg;
    logic [11:0]       rb_reg;        // ratio * bus_multiple
    logic [18:0]       num_reg;       // ratio * bus_multiple * 100 + 1
    logic [15:0]       cur_reg;
    logic [IDX_W-1:0]  scan_idx_reg;
    logic [IDX_W-1:0]  chk_idx_reg;
    logic              chk_vld_reg;
    logic [11:0]       chosen_reg;
    logic [7:0]        vcode_reg;
    logic [13:0]       rem_reg;
    logic [10:0]       div_reg;
    logic [7:0]        quo_reg;
    logic [1:0]        step_reg;
    logic              written_reg;
    logic              m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;
    logic [M_TUSER_W-1:0] m_tuser_reg;

    logic              accept;
    logic [CNT_W-1:0]  count_clamped;
    logic              load_in_range;
    logic              mem_we;
    logic [IDX_W-1:0]  mem_wr_addr;
    point_t            rd_point_reg;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    assign count_clamped = ({27'b0, point_count_reg} > 32'(MAX_POINTS))
                           ? CNT_W'(MAX_POINTS) : CNT_W'(point_count_reg);
    assign load_in_range = ({28'b0, in_entry_index} < 32'(MAX_POINTS));
    assign mem_we        = accept && (in_op == OP_LOAD) && load_in_range;
    assign mem_wr_addr   = IDX_W'(in_entry_index);

    // point table; the write happens at acceptance, scans come later, so no overlap
    point_t point_mem [MAX_POINTS];

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            point_mem[mem_wr_addr] <= '{mv: in_entry_mv, mhz: in_entry_mhz};
        end
        rd_point_reg <= point_mem[scan_idx_reg];
    end

    // decode: divide by 3 through the reciprocal
    logic [38:0] dec_prod;
    logic [17:0] dec_quot;
    logic [15:0] cur_next;

    assign dec_prod = 39'(num_reg) * 39'(DIV3_RECIP);
    assign dec_quot = dec_prod[DIV3_SHIFT +: 18];
    assign cur_next = (|dec_quot[17:16]) ? 16'hffff : dec_quot[15:0];

    // scan hit: entry reaches the target, or entry 0 as fallback
    logic scan_hit;
    assign scan_hit = chk_vld_reg
                      && (({4'b0, rd_point_reg.mhz} >= target_reg) || (chk_idx_reg == '0));

    // encode of the selected entry
    logic [12:0] vdiff;
    logic [15:0] ratio_base;
    logic [15:0] ratio_num;

    assign vdiff      = rd_point_reg.mv - VOLT_BASE_MV;
    assign ratio_base = 16'(rd_point_reg.mhz) + RATIO_OFFSET_MHZ;
    assign ratio_num  = 16'(ratio_base * 16'd3);

    // ratio divider, two quotient bits per cycle; quotient is known to stay below 256
    logic [17:0] rem_w;
    logic [7:0]  quo_w;
    logic [17:0] trial;
    logic [2:0]  bit_pos;

    always_comb begin
        rem_w   = {4'b0, rem_reg};
        quo_w   = quo_reg;
        trial   = '0;
        bit_pos = '0;
        for (int j = 0; j < 2; j++) begin
            bit_pos = 3'd7 - {step_reg, 1'b0} - 3'(j);
            trial   = 18'(div_reg) << bit_pos;
            if (rem_w >= trial) begin
                rem_w          = rem_w - trial;
                quo_w[bit_pos] = 1'b1;
            end
        end
    end

    logic [7:0] rcode;
    assign rcode = (bus_mult_reg == '0) ? 8'd0 : quo_w;

    // result fields
    logic [15:0] out_cur;
    logic [15:0] out_cw;
    assign out_cur = status_reg ? 16'd0 : cur_reg;
    assign out_cw  = status_reg ? 16'd0 : control_word_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            control_word_reg <= '0;
            m_tvalid_reg     <= 1'b0;
            chk_vld_reg      <= 1'b0;
            status_reg       <= 1'b0;
            written_reg      <= 1'b0;
            step_reg         <= '0;
        end else begin
            // in ST_FINISH the output register is reloaded below instead
            if (m_tvalid_reg && m_tready && (state_reg != ST_FINISH)) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        op_reg      <= in_op;
                        target_reg  <= in_target_mhz;
                        count_reg   <= count_clamped;
                        status_reg  <= (in_op != OP_LOAD) && (count_clamped == '0);
                        written_reg <= 1'b0;
                        chosen_reg  <= '0;
                        state_reg   <= ST_DEC_MUL;
                    end
                end
                ST_DEC_MUL: begin
                    rb_reg    <= 12'({4'b0, control_word_reg[15:8]} * {8'b0, bus_mult_reg});
                    state_reg <= ST_DEC_SCALE;
                end
                ST_DEC_SCALE: begin
                    num_reg   <= 19'(rb_reg) * 19'd100 + 19'd1;
                    state_reg <= ST_DEC_DIV;
                end
                ST_DEC_DIV: begin
                    cur_reg <= cur_next;
                    if ((op_reg == OP_SET) && !status_reg && (target_reg != cur_next)) begin
                        scan_idx_reg <= IDX_W'(count_reg - CNT_W'(1));
                        chk_vld_reg  <= 1'b0;
                        state_reg    <= ST_SCAN;
                    end else begin
                        state_reg <= ST_FINISH;
                    end
                end
                ST_SCAN: begin
                    // memory data is registered; chk_idx_reg tracks the address it belongs to
                    chk_idx_reg <= scan_idx_reg;
                    chk_vld_reg <= 1'b1;
                    if (scan_hit) begin
                        chosen_reg  <= rd_point_reg.mhz;
                        vcode_reg   <= vdiff[11:4];
                        rem_reg     <= ratio_num[13:0];
                        div_reg     <= 11'(bus_mult_reg) * MHZ_PER_STEP;
                        quo_reg     <= '0;
                        step_reg    <= '0;
                        state_reg   <= ST_DIV;
                    end else if (scan_idx_reg != '0) begin
                        scan_idx_reg <= scan_idx_reg - IDX_W'(1);
                    end
                end
                ST_DIV: begin
                    rem_reg  <= rem_w[13:0];
                    quo_reg  <= quo_w;
                    step_reg <= step_reg + 2'd1;
                    if (step_reg == 2'd3) begin
                        control_word_reg <= {rcode, vcode_reg};
                        written_reg      <= 1'b1;
                        state_reg        <= ST_FINISH;
                    end
                end
                ST_FINISH: begin
                    if (!m_tvalid_reg || m_tready) begin
                        m_tvalid_reg <= 1'b1;
                        m_tuser_reg  <= status_reg;
                        m_tdata_reg  <= {3'b0, written_reg, out_cw, chosen_reg, out_cur};
                        state_reg    <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

FILE: rtl/ops_checker.sv
// Port-level checker of the operating point selector and its bind.
`include "assert_macros.svh"

module ops_checker
    import ops_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata,
    input logic [M_TUSER_W-1:0] m_tuser
);

    // a stalled result transaction holds
    `OPS_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))

    // unsupported answers carry all-zero data
    `OPS_ASSERT_IMPLIES(a_unsup_zero, aclk, aresetn, m_tvalid && m_tuser[0], m_tdata == '0)

    // no chosen frequency unless the control word was written
    `OPS_ASSERT_IMPLIES(a_chosen_only_written, aclk, aresetn, m_tvalid && !m_tdata[OUT_WRITTEN_BIT], m_tdata[OUT_CHOSEN_LSB +: 12] == 12'd0)

    // one transaction in flight: input closes right after an accept
    `OPS_ASSERT_NEXT(a_one_in_flight, aclk, aresetn, s_tvalid && s_tready, !s_tready)

endmodule

bind operating_point_selector_top ops_checker u_ops_checker (.*);

FILE: tb/tb_operating_point_selector_top.sv
// Self-checking stream testbench for the operating point selector.
module tb_operating_point_selector_top;
    import ops_pkg::*;

    // Op codes not named by the package; the block treats both as a read.
    localparam logic [1:0] OP_READ  = 2'd2;
    localparam logic [1:0] OP_SPARE = 2'd3;

    localparam int MAX_PTS         = 16;
    localparam int LIVE            = 0;   // state advanced on accepted transactions
    localparam int PLAN            = 1;   // state advanced while items are generated
    localparam int N_PHASES        = 10;
    localparam int ITEMS_PER_PHASE = 48;
    localparam int QUIET_LIMIT     = 2000;
    localparam int DRAIN_CYCLES    = 60;

    localparam logic [31:0] MV_BASE    = 32'd700;
    localparam logic [31:0] MHZ_OFFSET = 32'd30;
    localparam logic [31:0] MHZ_STEP   = 32'd100;

    typedef struct packed {
        logic [1:0]  op;
        logic [3:0]  index;
        logic [11:0] mhz;
        logic [12:0] mv;
        logic [15:0] target;
    } op_item_t;

    typedef struct packed {
        logic        status;
        logic [15:0] current_mhz;
        logic [11:0] chosen_mhz;
        logic [15:0] control_low;
        logic        control_written;
    } op_result_t;

    logic                  aclk;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata   = '0;
    logic [S_TUSER_W-1:0]  s_tuser   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic [M_TUSER_W-1:0]  m_tuser;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [0:0]            cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    // Two copies of the selector state: [LIVE] and [PLAN].
    logic [3:0]  bus_mult_q  [2];
    logic [4:0]  point_cnt_q [2];
    logic [11:0] tbl_mhz     [2][MAX_PTS];
    logic [12:0] tbl_mv      [2][MAX_PTS];
    logic [15:0] ctrl_word   [2];

    op_item_t   pending_q[$];      // items waiting for the driver
    op_result_t result_due_q[$];   // predicted results, oldest first

    op_item_t   drv_item;
    op_result_t due_res;
    op_result_t got_res;
    logic       drv_busy;
    int         send_hold, recv_hold, hold_n;
    int         send_gap_max = 12;
    int         recv_gap_max = 12;
    int         n_queued, n_accepted, n_checked, n_cfg, n_errors, quiet_cycles;
    int         op_seen[4];

    operating_point_selector_top u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // Frequency decoded from the control word: (ratio*100*bus+1)/3, saturated.
    function automatic logic [15:0] decode_mhz(input int s);
        logic [31:0] f;
        f = (32'(ctrl_word[s][15:8]) * MHZ_STEP * 32'(bus_mult_q[s]) + 32'd1) / 32'd3;
        return (f > 32'hffff) ? 16'hffff : f[15:0];
    endfunction

    // Advances one state copy by one item and returns the result it gives.
    function automatic op_result_t step_selector(input int s, input op_item_t it);
        op_result_t  r;
        int          cnt, i;
        logic [31:0] f, v, vcode, rcode;
        r             = '0;
        cnt           = (point_cnt_q[s] > MAX_PTS) ? MAX_PTS : int'(point_cnt_q[s]);
        r.current_mhz = decode_mhz(s);
        if (it.op == OP_LOAD) begin
            tbl_mhz[s][it.index] = it.mhz;
            tbl_mv[s][it.index]  = it.mv;
        end else if (cnt == 0) begin
            r.status      = 1'b1;
            r.current_mhz = '0;
        end else if (it.op == OP_SET && it.target != r.current_mhz) begin
            // walk down from the last valid entry; entry 0 is the fallback
            i = cnt - 1;
            while (i > 0 && 16'(tbl_mhz[s][i]) < it.target)
                i--;
            f     = 32'(tbl_mhz[s][i]);
            v     = 32'(tbl_mv[s][i]);
            vcode = (v - MV_BASE) >> 4;   // wraps below the base voltage
            rcode = '0;
            if (bus_mult_q[s] != 0)
                rcode = (32'd3 * (f + MHZ_OFFSET)) / (MHZ_STEP * 32'(bus_mult_q[s]));
            ctrl_word[s]      = {rcode[7:0], vcode[7:0]};
            r.chosen_mhz      = f[11:0];
            r.control_written = 1'b1;
        end
        r.control_low = r.status ? 16'h0 : ctrl_word[s];
        return r;
    endfunction

    function automatic op_item_t mk_item(input logic [1:0] op, input logic [3:0] idx,
                                         input logic [11:0] mhz, input logic [12:0] mv,
                                         input logic [15:0] target);
        op_item_t it;
        it.op     = op;
        it.index  = idx;
        it.mhz    = mhz;
        it.mv     = mv;
        it.target = target;
        return it;
    endfunction

    // Random item; set targets are aimed at table entries and the current frequency.
    function automatic op_item_t rand_item();
        op_item_t    it;
        logic [15:0] near;
        int          pick;
        it   = mk_item(OP_READ, 4'($urandom), 12'($urandom), 13'($urandom), 16'($urandom));
        near = 16'(tbl_mhz[PLAN][$urandom_range(0, MAX_PTS - 1)]);
        pick = $urandom_range(0, 19);
        if (pick < 5) begin
            it.op = OP_LOAD;
            if ($urandom_range(0, 1) == 0)
                it.mhz = 12'(4095 - int'(it.index) * 250 - $urandom_range(0, 200));
            case ($urandom_range(0, 9))
                0, 1:    ;                                        // full 13-bit value
                2:       it.mv = 13'($urandom_range(0, 699));     // below the base voltage
                default: it.mv = 13'($urandom_range(700, 4780));
            endcase
        end else if (pick < 15) begin
            it.op = OP_SET;
            case ($urandom_range(0, 9))
                0:       it.target = decode_mhz(PLAN);
                1:       it.target = 16'h0000;
                2:       it.target = 16'hffff;
                3, 4:    it.target = near;
                5:       it.target = near + 16'd1;
                6:       it.target = near - 16'd1;
                7:       it.target = 16'($urandom_range(0, 4095));
                default: ;
            endcase
        end else if (pick < 19) begin
            it.op = OP_READ;
        end else begin
            it.op = OP_SPARE;
        end
        return it;
    endfunction

    task automatic queue_item(input op_item_t it);
        op_result_t unused;
        unused = step_selector(PLAN, it);
        pending_q.push_back(it);
        n_queued++;
    endtask

    // Register write through the configuration channel; only called while idle.
    task automatic write_reg(input logic [0:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready)
            @(posedge aclk);
        cfg_valid <= 1'b0;
        if (idx == REG_BUS_MULTIPLE)
            bus_mult_q[PLAN] = val[3:0];
        else
            point_cnt_q[PLAN] = val;
    endtask

    // Full descending table: entry 0 fastest, entry 15 slowest.
    task automatic load_sorted_table();
        int i;
        for (i = 0; i < MAX_PTS; i++)
            queue_item(mk_item(OP_LOAD, 4'(i), 12'(4095 - i * 260 - $urandom_range(0, 40)),
                               13'(4780 - i * 250 - $urandom_range(0, 100)), '0));
    endtask

    // Stimulus: reset, directed items, then random phases with new register settings.
    initial begin
        int          ph, n, i;
        logic [4:0]  bus_val, cnt_val;
        for (i = 0; i < 2; i++) begin
            bus_mult_q[i]  = BUS_MULT_RESET;
            point_cnt_q[i] = '0;
            ctrl_word[i]   = '0;
            for (n = 0; n < MAX_PTS; n++) begin
                tbl_mhz[i][n] = '0;
                tbl_mv[i][n]  = '0;
            end
        end
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // no points loaded yet: set and reads answer unsupported
        queue_item(mk_item(OP_READ, '0, '0, '0, '0));
        queue_item(mk_item(OP_SET, '0, '0, '0, 16'd1000));
        queue_item(mk_item(OP_SPARE, '0, '0, '0, '0));
        // every entry is written before any count is set, so no scan sees a blank entry;
        // the extremes sit at both ends, including voltages that wrap the code
        for (i = 0; i < MAX_PTS; i++)
            queue_item(mk_item(OP_LOAD, 4'(i), 12'(4095 - (i * 4095) / 15),
                               (i == 0)  ? 13'd4780 :
                               (i == 13) ? 13'h1fff :
                               (i == 14) ? 13'd0    :
                               (i == 15) ? 13'd700  : 13'(4700 - i * 250), '0));
        wait (n_checked == n_queued);
        write_reg(REG_BUS_MULTIPLE, 5'd8);
        write_reg(REG_POINT_COUNT, 5'd16);
        queue_item(mk_item(OP_READ, '0, '0, '0, '0));
        queue_item(mk_item(OP_SET, '0, '0, '0, 16'd0));        // equals current: no write
        queue_item(mk_item(OP_SET, '0, '0, '0, 16'hffff));     // nothing fast enough: entry 0
        queue_item(mk_item(OP_SET, '0, '0, '0, 16'd1));        // wrapped voltage code
        queue_item(mk_item(OP_SET, '0, '0, '0, decode_mhz(PLAN)));
        queue_item(mk_item(OP_SPARE, '0, '0, '0, '0));

        for (ph = 0; ph < N_PHASES; ph++) begin
            wait (n_checked == n_queued);
            send_gap_max = (ph % 3 == 0) ? 0 : 12;
            recv_gap_max = (ph % 4 == 2) ? 0 : 12;
            case (ph)
                0:       begin bus_val = 5'd1;  cnt_val = 5'd16; end
                1:       begin bus_val = 5'd0;  cnt_val = 5'd5;  end   // ratio code forced to 0
                2:       begin bus_val = 5'd15; cnt_val = 5'd31; end   // count clamps to 16
                3:       begin bus_val = 5'h1f; cnt_val = 5'd0;  end   // unsupported phase
                4:       begin bus_val = 5'd8;  cnt_val = 5'd1;  end
                5:       begin bus_val = 5'd2;  cnt_val = 5'd17; end
                default: begin
                    bus_val = ($urandom_range(0, 3) == 0) ? 5'($urandom_range(0, 31))
                                                          : 5'($urandom_range(1, 8));
                    cnt_val = ($urandom_range(0, 3) == 0) ? 5'($urandom_range(0, 31))
                                                          : 5'($urandom_range(1, 16));
                end
            endcase
            write_reg(REG_BUS_MULTIPLE, bus_val);
            write_reg(REG_POINT_COUNT, cnt_val);
            if ($urandom_range(0, 2) == 0)
                load_sorted_table();
            for (n = 0; n < ITEMS_PER_PHASE; n++)
                queue_item(rand_item());
        end

        wait (n_checked == n_queued);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (result_due_q.size() != 0) begin
            $error("%0d predicted results never arrived", result_due_q.size());
            n_errors++;
        end
        $display("Ran %0d transactions (load %0d, set %0d, read %0d, spare op %0d),",
                 n_accepted, op_seen[0], op_seen[1], op_seen[2], op_seen[3]);
        $display("checked %0d results across %0d register writes; %0d mismatches.",
                 n_checked, n_cfg, n_errors);
        if (n_errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // Driver: presents queued items, predicts each one as it is accepted.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid  <= 1'b0;
            send_hold <= 0;
        end else begin
            drv_busy = s_tvalid && !s_tready;
            if (s_tvalid && s_tready) begin
                result_due_q.push_back(step_selector(LIVE, drv_item));
                op_seen[drv_item.op]++;
                n_accepted++;
            end
            if (drv_busy) begin
                // keep the current item on the bus
            end else if (send_hold != 0) begin
                s_tvalid  <= 1'b0;
                send_hold <= send_hold - 1;
            end else if (pending_q.size() != 0) begin
                drv_item  = pending_q.pop_front();
                s_tdata   <= {3'b0, drv_item.target, drv_item.mv, drv_item.mhz, drv_item.index};
                s_tuser   <= drv_item.op;
                s_tvalid  <= 1'b1;
                send_hold <= $urandom_range(0, send_gap_max);
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Monitor: random stalls on the result side, field-by-field compare.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready  <= 1'b0;
            recv_hold <= 0;
        end else begin
            if (m_tvalid && m_tready) begin
                n_checked++;
                got_res = {m_tuser[0], m_tdata[43:28], m_tdata[27:16], m_tdata[15:0],
                           m_tdata[44]};
                got_res = '{status: m_tuser[0], current_mhz: m_tdata[15:0],
                            chosen_mhz: m_tdata[27:16], control_low: m_tdata[43:28],
                            control_written: m_tdata[44]};
                if (result_due_q.size() == 0) begin
                    $error("result transaction with no prediction waiting");
                    n_errors++;
                end else begin
                    due_res = result_due_q.pop_front();
                    if (got_res.status !== due_res.status) begin
                        $error("status: expected %0d, got %0d", due_res.status, got_res.status);
                        n_errors++;
                    end
                    if (got_res.current_mhz !== due_res.current_mhz) begin
                        $error("current_mhz: expected %0d, got %0d",
                               due_res.current_mhz, got_res.current_mhz);
                        n_errors++;
                    end
                    if (got_res.chosen_mhz !== due_res.chosen_mhz) begin
                        $error("chosen_mhz: expected %0d, got %0d",
                               due_res.chosen_mhz, got_res.chosen_mhz);
                        n_errors++;
                    end
                    if (got_res.control_low !== due_res.control_low) begin
                        $error("control_low: expected %h, got %h",
                               due_res.control_low, got_res.control_low);
                        n_errors++;
                    end
                    if (got_res.control_written !== due_res.control_written) begin
                        $error("control_written: expected %0d, got %0d",
                               due_res.control_written, got_res.control_written);
                        n_errors++;
                    end
                end
                hold_n = $urandom_range(0, recv_gap_max);
            end else begin
                hold_n = (recv_hold != 0) ? recv_hold - 1 : 0;
            end
            recv_hold <= hold_n;
            m_tready  <= (hold_n == 0);
        end
    end

    // Register writes take effect in the live copy at the handshake.
    always @(posedge aclk) begin
        if (aresetn && cfg_valid && cfg_ready) begin
            n_cfg++;
            if (cfg_index == REG_BUS_MULTIPLE)
                bus_mult_q[LIVE] = cfg_data[3:0];
            else
                point_cnt_q[LIVE] = cfg_data;
        end
    end

    // Watchdog: too long without any transaction on any channel.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $error("no transaction for %0d cycles", QUIET_LIMIT);
            $display("CHECK FAILED");
            $finish;
        end
    end

endmodule
